### sv/rcst_pkg.sv
// ----------------------------------------------------------------------------
// rcst_pkg
// shared sizes and types of the reference count slot table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcst_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned ADDR_WIDTH = 32;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W     = $clog2(QUEUE_DEPTH + 1);

  // one reassignment that changes a slot
  typedef struct packed {
    logic [ADDR_WIDTH-1:0] old_addr;
    logic [ADDR_WIDTH-1:0] new_addr;
  } op_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### sv/rcst_front.sv
// ----------------------------------------------------------------------------
// rcst_front
// slot table; accepts reassignments and forwards those that change a slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcst_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [rcst_pkg::SLOT_W-1:0]       slot_index_i,
  input  wire logic [rcst_pkg::ADDR_WIDTH-1:0]   new_address_i,
  input  wire rcst_pkg::q_stat_t                 q_stat_i,
  output logic                                   push_o,
  output rcst_pkg::op_t                          push_op_o
);

  logic [rcst_pkg::ADDR_WIDTH-1:0] slot_q [rcst_pkg::SLOTS];
  logic [rcst_pkg::ADDR_WIDTH-1:0] old_addr;
  logic                            accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign old_addr   = slot_q[slot_index_i];

  // same address: no change, nothing to count
  assign push_o             = accept && (old_addr != new_address_i);
  assign push_op_o.old_addr = old_addr;
  assign push_op_o.new_addr = new_address_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rcst_pkg::SLOTS; i++) begin
        slot_q[i] <= '0;
      end
    end else if (push_o) begin
      slot_q[slot_index_i] <= new_address_i;
    end
  end

endmodule

`default_nettype wire

### sv/rcst_queue.sv
// ----------------------------------------------------------------------------
// rcst_queue
// short fifo of slot changes between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcst_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rcst_pkg::op_t push_op_i,
  input  wire logic          pop_i,
  output rcst_pkg::op_t      pop_op_o,
  output rcst_pkg::q_stat_t  q_stat_o
);

  rcst_pkg::op_t                  mem_q [rcst_pkg::QUEUE_DEPTH];
  logic [rcst_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rcst_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [rcst_pkg::QLVL_W-1:0]    level_q, level_d;

  assign q_stat_o.full  = (level_q == rcst_pkg::QLVL_W'(rcst_pkg::QUEUE_DEPTH));
  assign q_stat_o.empty = (level_q == '0);
  assign pop_op_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == rcst_pkg::QPTR_W'(rcst_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == rcst_pkg::QPTR_W'(rcst_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    // level holds when both or neither happen
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

### sv/rcst_back.sv
// ----------------------------------------------------------------------------
// rcst_back
// count table; applies one slot change a cycle while the result register can take its output, and emits freed addresses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcst_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rcst_pkg::q_stat_t               q_stat_i,
  input  wire rcst_pkg::op_t                   pop_op_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [rcst_pkg::ADDR_WIDTH-1:0]      freed_address_o
);

  localparam int unsigned SLOTS  = rcst_pkg::SLOTS;
  localparam int unsigned SLOT_W = rcst_pkg::SLOT_W;
  localparam int unsigned CNT_W  = rcst_pkg::CNT_W;

  logic [rcst_pkg::ADDR_WIDTH-1:0] key_q [SLOTS];
  logic [CNT_W-1:0]                val_q [SLOTS];
  logic [CNT_W-1:0]                val_d [SLOTS];

  logic [SLOTS-1:0]  old_hit, new_hit, free_vec;
  logic [SLOT_W-1:0] old_sel, new_sel, free_sel;
  logic              old_found, new_found, free_found;
  logic              old_freed;
  logic              key_we;
  logic [SLOT_W-1:0] key_idx;

  logic                            out_valid_q, out_valid_d;
  logic [rcst_pkg::ADDR_WIDTH-1:0] freed_q, freed_d;

  // take a change when the result register can hold what it may produce
  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int e = 0; e < SLOTS; e++) begin
      old_hit[e] = (val_q[e] != '0) && (key_q[e] == pop_op_i.old_addr)
                   && (pop_op_i.old_addr != '0);
      new_hit[e] = (val_q[e] != '0) && (key_q[e] == pop_op_i.new_addr)
                   && (pop_op_i.new_addr != '0);
    end
  end

  // lowest matching entries
  always_comb begin
    old_sel = '0;
    new_sel = '0;
    for (int e = SLOTS - 1; e >= 0; e--) begin
      if (old_hit[e]) old_sel = SLOT_W'(e);
      if (new_hit[e]) new_sel = SLOT_W'(e);
    end
  end

  assign old_found = |old_hit;
  assign new_found = |new_hit;
  assign old_freed = old_found && (val_q[old_sel] == CNT_W'(1));

  // free after the decrement: an entry that just dropped to zero counts
  always_comb begin
    for (int e = 0; e < SLOTS; e++) begin
      free_vec[e] = (val_q[e] == '0) || (old_freed && (old_sel == SLOT_W'(e)));
    end
    free_sel = '0;
    for (int e = SLOTS - 1; e >= 0; e--) begin
      if (free_vec[e]) free_sel = SLOT_W'(e);
    end
  end

  assign free_found = |free_vec;

  always_comb begin
    val_d   = val_q;
    key_we  = 1'b0;
    key_idx = free_sel;
    if (pop_o) begin
      if (old_found) begin
        val_d[old_sel] = val_q[old_sel] - 1'b1;
      end
      if (pop_op_i.new_addr != '0) begin
        priority if (new_found) begin
          if (val_d[new_sel] < CNT_W'(SLOTS)) begin
            val_d[new_sel] = val_d[new_sel] + 1'b1;
          end
        end else if (free_found) begin
          key_we          = 1'b1;
          val_d[free_sel] = CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    freed_d     = freed_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && old_freed) begin
      out_valid_d = 1'b1;
      freed_d     = pop_op_i.old_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < SLOTS; e++) begin
        val_q[e] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      val_q       <= val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freed_q <= freed_d;
    if (key_we) begin
      key_q[key_idx] <= pop_op_i.new_addr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign freed_address_o = freed_q;

endmodule

`default_nettype wire

### sv/reference_count_slot_table.sv
// ----------------------------------------------------------------------------
// reference_count_slot_table
// pointer slots with reference counted addresses; emits addresses freed
// ----------------------------------------------------------------------------
// a freed address passes through the change queue and then the back end's result register before it is offered
// throughput: one beat per cycle while the change queue is not full, set by the
//   count update in the back end (parallel key compare over the count table)
// the two-entry change queue lets the front keep accepting while a result waits
// reset: asynchronous, active low; slots go null, all count entries free,
//   no clearing pass, the block is ready as soon as reset is released
`timescale 1ns / 1ps
`default_nettype none

module reference_count_slot_table (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input beats
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [rcst_pkg::SLOT_W-1:0]     slot_index_i,
  input  wire logic [rcst_pkg::ADDR_WIDTH-1:0] new_address_i,
  // result beats
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [rcst_pkg::ADDR_WIDTH-1:0]      freed_address_o
);

  // front to queue
  logic              push;
  rcst_pkg::op_t     push_op;
  // queue to back
  logic              pop;
  rcst_pkg::op_t     pop_op;
  rcst_pkg::q_stat_t q_stat;

  // front: slot table, filters reassignments that change nothing
  rcst_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .slot_index_i  (slot_index_i),
    .new_address_i (new_address_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_op_o     (push_op)
  );

  // change queue: old and new address of each slot that changed
  rcst_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .pop_op_o  (pop_op),
    .q_stat_o  (q_stat)
  );

  // back: decrement old, increment or claim new, register the freed address
  rcst_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .pop_op_i        (pop_op),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .freed_address_o (freed_address_o)
  );

  // null is never counted, so never freed
  a_freed_not_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (freed_address_o != '0))
    else $error("freed address is null");

  // back only takes changes that are there
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty change queue");

  // queued changes always move a slot to a different address
  a_change_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (pop_op.old_addr != pop_op.new_addr))
    else $error("queued change does not change the slot");

endmodule

`default_nettype wire

### dv/tb_reference_count_slot_table.sv
// ----------------------------------------------------------------------------
// tb_reference_count_slot_table
// self-checking bench: a behavioral copy of the slot and count tables predicts
// each freed address, and a monitor compares the result beats against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reference_count_slot_table;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned HOT_ADDRS    = 6;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 435;

  // clock, reset and the block's inputs, all known from time zero
  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid    = 1'b0;
  logic [rcst_pkg::SLOT_W-1:0]     slot_index  = '0;
  logic [rcst_pkg::ADDR_WIDTH-1:0] new_address = '0;
  logic                            out_ready   = 1'b0;

  logic                            in_ready_o;
  logic                            out_valid_o;
  logic [rcst_pkg::ADDR_WIDTH-1:0] freed_address_o;

  // behavioral copy of the slot and count tables
  logic [rcst_pkg::ADDR_WIDTH-1:0] slot_addr_m [rcst_pkg::SLOTS];
  logic [rcst_pkg::ADDR_WIDTH-1:0] cnt_key_m   [rcst_pkg::SLOTS];
  logic [rcst_pkg::CNT_W-1:0]      cnt_val_m   [rcst_pkg::SLOTS];

  // addresses predicted to be freed, oldest first
  logic [rcst_pkg::ADDR_WIDTH-1:0] freed_q [$];
  logic [rcst_pkg::ADDR_WIDTH-1:0] want_addr;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  reference_count_slot_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .slot_index_i    (slot_index),
    .new_address_i   (new_address),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .freed_address_o (freed_address_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // live count entry that owns addr, or -1 when none does
  function automatic int find_live(input logic [rcst_pkg::ADDR_WIDTH-1:0] addr);
    for (int e = 0; e < rcst_pkg::SLOTS; e++) begin
      if (cnt_val_m[e] != '0 && cnt_key_m[e] == addr) return e;
    end
    return -1;
  endfunction

  // apply one accepted reassignment to the table copy and queue any free
  task automatic predict_reassign(input logic [rcst_pkg::SLOT_W-1:0] slot,
                                  input logic [rcst_pkg::ADDR_WIDTH-1:0] addr);
    logic [rcst_pkg::ADDR_WIDTH-1:0] old_addr;
    int                              e;
    old_addr = slot_addr_m[slot];
    // same address again: slot and counts stay as they are
    if (old_addr == addr) return;
    // old address loses a reference; the last one leaving frees it
    if (old_addr != '0) begin
      e = find_live(old_addr);
      if (e >= 0) begin
        cnt_val_m[e] = cnt_val_m[e] - 1'b1;
        if (cnt_val_m[e] == '0) freed_q.push_back(old_addr);
      end
    end
    slot_addr_m[slot] = addr;
    // null is never counted
    if (addr != '0) begin
      e = find_live(addr);
      if (e >= 0) begin
        if (cnt_val_m[e] < rcst_pkg::CNT_W'(rcst_pkg::SLOTS)) begin
          cnt_val_m[e] = cnt_val_m[e] + 1'b1;
        end
      end else begin
        // claim the lowest free entry
        for (int f = 0; f < rcst_pkg::SLOTS; f++) begin
          if (cnt_val_m[f] == '0) begin
            cnt_key_m[f] = addr;
            cnt_val_m[f] = rcst_pkg::CNT_W'(1);
            break;
          end
        end
      end
    end
  endtask

  // one input beat; entered and left at a falling edge, valid stays high
  // across back-to-back beats so it is never lowered and raised in one step
  task automatic send_beat(input logic [rcst_pkg::SLOT_W-1:0] slot,
                           input logic [rcst_pkg::ADDR_WIDTH-1:0] addr);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    slot_index  <= slot;
    new_address <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_reassign(slot, addr);
    @(negedge clk_i);
  endtask

  // hold the sender off until every predicted free has come out
  task automatic wait_for_drain(input int unsigned settle);
    in_valid <= 1'b0;
    while (freed_q.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // result monitor: each accepted beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (freed_q.size() == 0) begin
        $error("freed_address: expected no beat, got %h", freed_address_o);
        mismatches <= mismatches + 1;
      end else begin
        want_addr = freed_q.pop_front();
        if (freed_address_o !== want_addr) begin
          $error("freed_address: expected %h, got %h", want_addr, freed_address_o);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // null onto null, claim, same address again, release to null
  task automatic test_null_and_same();
    send_beat(rcst_pkg::SLOT_W'(0), '0);
    send_beat(rcst_pkg::SLOT_W'(rcst_pkg::SLOTS - 1), rcst_pkg::ADDR_WIDTH'(1));
    send_beat(rcst_pkg::SLOT_W'(rcst_pkg::SLOTS - 1), rcst_pkg::ADDR_WIDTH'(1));
    send_beat(rcst_pkg::SLOT_W'(rcst_pkg::SLOTS - 1), '0);
  endtask

  // shared address: freed only when the second holder moves away
  task automatic test_move_between_addresses();
    send_beat(rcst_pkg::SLOT_W'(3), 32'h8000_0000);
    send_beat(rcst_pkg::SLOT_W'(7), 32'h8000_0000);
    send_beat(rcst_pkg::SLOT_W'(3), 32'h7fff_ffff);
    send_beat(rcst_pkg::SLOT_W'(7), 32'h7fff_ffff);
    send_beat(rcst_pkg::SLOT_W'(3), '0);
  endtask

  // every slot on the all-ones address drives one count to its ceiling;
  // the random traffic that follows unwinds it
  task automatic test_full_sharing();
    for (int s = 0; s < rcst_pkg::SLOTS; s++) send_beat(rcst_pkg::SLOT_W'(s), '1);
  endtask

  // mostly shared hot addresses so counts climb and fall, with nulls,
  // repeats of the held address, fresh full-width addresses and full sweeps
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    logic [rcst_pkg::ADDR_WIDTH-1:0] hot [HOT_ADDRS];
    logic [rcst_pkg::ADDR_WIDTH-1:0] addr;
    logic [rcst_pkg::SLOT_W-1:0]     slot;
    int unsigned                     sent;
    int unsigned                     pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int h = 0; h < HOT_ADDRS; h++) hot[h] = rcst_pkg::ADDR_WIDTH'($urandom());
    hot[0] = $urandom_range(1) ? '1 : rcst_pkg::ADDR_WIDTH'(1);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        addr = hot[$urandom_range(HOT_ADDRS - 1)];
        for (int s = 0; s < rcst_pkg::SLOTS; s++) send_beat(rcst_pkg::SLOT_W'(s), addr);
        sent += rcst_pkg::SLOTS;
      end else begin
        slot = rcst_pkg::SLOT_W'($urandom_range(rcst_pkg::SLOTS - 1));
        if (pick < 17)      addr = '0;
        else if (pick < 30) addr = slot_addr_m[slot];
        else if (pick < 80) addr = hot[$urandom_range(HOT_ADDRS - 1)];
        else                addr = rcst_pkg::ADDR_WIDTH'($urandom());
        send_beat(slot, addr);
        sent++;
      end
      // let the hot set drift so old addresses get released for good
      if ($urandom_range(39) == 0) begin
        hot[$urandom_range(HOT_ADDRS - 1)] = rcst_pkg::ADDR_WIDTH'($urandom());
      end
    end
  endtask

  initial begin
    for (int e = 0; e < rcst_pkg::SLOTS; e++) begin
      slot_addr_m[e] = '0;
      cnt_key_m[e]   = '0;
      cnt_val_m[e]   = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_null_and_same();
    test_move_between_addresses();
    test_full_sharing();

    test_random_traffic(PHASE_ITEMS, 0, 0);
    // sender holds off until the pipeline has emptied
    wait_for_drain(4);
    test_random_traffic(PHASE_ITEMS, 50, 0);
    test_random_traffic(PHASE_ITEMS, 0, 50);
    wait_for_drain(4);
    test_random_traffic(PHASE_ITEMS, 23, 23);

    // last beats out, then a settling wait to catch stray results
    wait_for_drain(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
